>>> src/bcc_pkg.sv
// bcc_pkg: widths, constants, register indexes, datapath op codes and types
// shared by the balance cascade controller modules; depends on nothing
package bcc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 2;
    localparam int ANGLE_W    = 17;
    localparam int GAIN_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int RATE_W     = 16;
    localparam int ECHO_W     = 16;
    localparam int DRIVE_W    = 32;

    localparam int TGT_W  = 6;
    localparam int TURN_W = 8;
    localparam int DAMP_W = 17;
    localparam int ERR_W  = 18;
    localparam int FE_W   = 18;
    localparam int SUM_W  = 15;
    localparam int NUM_W  = 22;
    localparam int MAG_W  = 21;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 72;

    localparam int GAIN_FRAC  = 16;
    localparam int ANGLE_FRAC = 8;

    localparam int FILT_NEW    = 3;
    localparam int FILT_OLD    = 7;
    localparam int RECIP_SHIFT = 24;
    localparam logic signed [MUL_W-1:0] RECIP_TEN = 32'sd1677722;

    localparam logic [MODE_W-1:0] MODE_FIXED    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOTE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OBSTACLE = 2'd2;

    localparam logic signed [TGT_W-1:0]  SPEED_LIMIT    = 6'sd22;
    localparam logic signed [TGT_W-1:0]  BACK_SPEED     = -6'sd15;
    localparam logic signed [TGT_W-1:0]  OBSTACLE_SPEED = -6'sd20;
    localparam logic signed [TURN_W-1:0] MAX_TURN       = 8'sd80;
    localparam logic signed [TURN_W-1:0] TURN_RESET     = 8'sd5;
    localparam logic [ECHO_W-1:0]        OBSTACLE_ECHO  = 16'd2320;
    localparam logic [DAMP_W-1:0]        DAMP_RESET     = 17'd52429;
    localparam logic [DAMP_W-1:0]        DAMP_IDLE      = 17'd32768;
    localparam logic signed [SUM_W-1:0]  SUM_LIMIT      = 15'sd10000;

    localparam logic [MODE_W-1:0]        RST_MODE          = MODE_FIXED;
    localparam logic signed [ANGLE_W-1:0] RST_BALANCE_ANGLE = -17'sd512;
    localparam logic signed [GAIN_W-1:0] RST_ANGLE_KP      = -32'sd11665408;
    localparam logic signed [GAIN_W-1:0] RST_ANGLE_KD      = 32'sd93848;
    localparam logic signed [GAIN_W-1:0] RST_SPEED_KP      = -32'sd29491;
    localparam logic signed [GAIN_W-1:0] RST_SPEED_KI      = -32'sd147;
    localparam logic signed [GAIN_W-1:0] RST_YAW_KP        = 32'sd1310720;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 3'd0,
        CFG_BALANCE_ANGLE = 3'd1,
        CFG_ANGLE_KP      = 3'd2,
        CFG_ANGLE_KD      = 3'd3,
        CFG_SPEED_KP      = 3'd4,
        CFG_SPEED_KI      = 3'd5,
        CFG_YAW_KP        = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [ANGLE_W-1:0] balance_angle;
        logic signed [GAIN_W-1:0]  angle_kp;
        logic signed [GAIN_W-1:0]  angle_kd;
        logic signed [GAIN_W-1:0]  speed_kp;
        logic signed [GAIN_W-1:0]  speed_ki;
        logic signed [GAIN_W-1:0]  yaw_kp;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TARGET,
        OP_FILT_NUM,
        OP_DIV,
        OP_FILT,
        OP_V_MUL_P,
        OP_V_MUL_I,
        OP_V_ADD,
        OP_V_DONE,
        OP_A_MUL_P,
        OP_A_MUL_D,
        OP_A_MUL_V,
        OP_A_SUB,
        OP_A_DONE,
        OP_P_DIFF,
        OP_P_DONE,
        OP_T_MUL_D,
        OP_T_MUL_P,
        OP_T_ADD,
        OP_T_DONE,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

endpackage

>>> src/bcc_cfg.sv
// bcc_cfg: configuration register file of the balance cascade controller
// depends on bcc_pkg
module bcc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bcc_pkg::t_cfg                 o_cfg
);
    import bcc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= RST_MODE;
            r_cfg.balance_angle <= RST_BALANCE_ANGLE;
            r_cfg.angle_kp      <= RST_ANGLE_KP;
            r_cfg.angle_kd      <= RST_ANGLE_KD;
            r_cfg.speed_kp      <= RST_SPEED_KP;
            r_cfg.speed_ki      <= RST_SPEED_KI;
            r_cfg.yaw_kp        <= RST_YAW_KP;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:          r_cfg.mode          <= i_cfg_data[MODE_W-1:0];
                CFG_BALANCE_ANGLE: r_cfg.balance_angle <= i_cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_KP:      r_cfg.angle_kp      <= i_cfg_data[GAIN_W-1:0];
                CFG_ANGLE_KD:      r_cfg.angle_kd      <= i_cfg_data[GAIN_W-1:0];
                CFG_SPEED_KP:      r_cfg.speed_kp      <= i_cfg_data[GAIN_W-1:0];
                CFG_SPEED_KI:      r_cfg.speed_ki      <= i_cfg_data[GAIN_W-1:0];
                CFG_YAW_KP:        r_cfg.yaw_kp        <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> src/bcc_ctrl.sv
// bcc_ctrl: sequencer of the balance cascade controller, one datapath op a cycle
// while an item runs, held while a full result is not taken; depends on bcc_pkg
module bcc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bcc_pkg::t_cmd o_cmd
);
    import bcc_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE     = 21'd1 << 0,
        S_TARGET   = 21'd1 << 1,
        S_FILT_NUM = 21'd1 << 2,
        S_DIV      = 21'd1 << 3,
        S_FILT     = 21'd1 << 4,
        S_V_MUL_P  = 21'd1 << 5,
        S_V_MUL_I  = 21'd1 << 6,
        S_V_ADD    = 21'd1 << 7,
        S_V_DONE   = 21'd1 << 8,
        S_A_MUL_P  = 21'd1 << 9,
        S_A_MUL_D  = 21'd1 << 10,
        S_A_MUL_V  = 21'd1 << 11,
        S_A_SUB    = 21'd1 << 12,
        S_A_DONE   = 21'd1 << 13,
        S_P_DIFF   = 21'd1 << 14,
        S_P_DONE   = 21'd1 << 15,
        S_T_MUL_D  = 21'd1 << 16,
        S_T_MUL_P  = 21'd1 << 17,
        S_T_ADD    = 21'd1 << 18,
        S_T_DONE   = 21'd1 << 19,
        S_OUT      = 21'd1 << 20
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state      = r_state;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op  = OP_LOAD;
                    n_state = S_TARGET;
                end
            end
            S_TARGET:   begin cmd.op = OP_TARGET;   n_state = S_FILT_NUM; end
            S_FILT_NUM: begin cmd.op = OP_FILT_NUM; n_state = S_DIV;      end
            S_DIV:      begin cmd.op = OP_DIV;      n_state = S_FILT;     end
            S_FILT:     begin cmd.op = OP_FILT;     n_state = S_V_MUL_P;  end
            S_V_MUL_P:  begin cmd.op = OP_V_MUL_P;  n_state = S_V_MUL_I;  end
            S_V_MUL_I:  begin cmd.op = OP_V_MUL_I;  n_state = S_V_ADD;    end
            S_V_ADD:    begin cmd.op = OP_V_ADD;    n_state = S_V_DONE;   end
            S_V_DONE:   begin cmd.op = OP_V_DONE;   n_state = S_A_MUL_P;  end
            S_A_MUL_P:  begin cmd.op = OP_A_MUL_P;  n_state = S_A_MUL_D;  end
            S_A_MUL_D:  begin cmd.op = OP_A_MUL_D;  n_state = S_A_MUL_V;  end
            S_A_MUL_V:  begin cmd.op = OP_A_MUL_V;  n_state = S_A_SUB;    end
            S_A_SUB:    begin cmd.op = OP_A_SUB;    n_state = S_A_DONE;   end
            S_A_DONE:   begin cmd.op = OP_A_DONE;   n_state = S_P_DIFF;   end
            S_P_DIFF:   begin cmd.op = OP_P_DIFF;   n_state = S_P_DONE;   end
            S_P_DONE:   begin cmd.op = OP_P_DONE;   n_state = S_T_MUL_D;  end
            S_T_MUL_D:  begin cmd.op = OP_T_MUL_D;  n_state = S_T_MUL_P;  end
            S_T_MUL_P:  begin cmd.op = OP_T_MUL_P;  n_state = S_T_ADD;    end
            S_T_ADD:    begin cmd.op = OP_T_ADD;    n_state = S_T_DONE;   end
            S_T_DONE:   begin cmd.op = OP_T_DONE;   n_state = S_OUT;      end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.op       = OP_OUT;
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register stays full until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

>>> src/bcc_dp.sv
// bcc_dp: datapath of the balance cascade controller: loop state, one shared
// signed multiplier, wide accumulator and truncating saturator; depends on bcc_pkg
module bcc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bcc_pkg::t_cmd                      i_cmd,
    input  bcc_pkg::t_cfg                      i_cfg,
    input  logic signed [bcc_pkg::COUNT_W-1:0] i_left_count,
    input  logic signed [bcc_pkg::COUNT_W-1:0] i_right_count,
    input  logic signed [bcc_pkg::ANGLE_W-1:0] i_pitch_angle,
    input  logic signed [bcc_pkg::RATE_W-1:0]  i_pitch_rate,
    input  logic signed [bcc_pkg::RATE_W-1:0]  i_yaw_rate,
    input  logic [bcc_pkg::ECHO_W-1:0]         i_echo_time,
    input  logic                               i_go_button,
    input  logic                               i_back_button,
    input  logic                               i_left_button,
    input  logic                               i_right_button,
    output logic signed [bcc_pkg::DRIVE_W-1:0] o_motor_one,
    output logic signed [bcc_pkg::DRIVE_W-1:0] o_motor_two,
    output logic signed [bcc_pkg::DRIVE_W-1:0] o_speed_term
);
    import bcc_pkg::*;

    localparam logic signed [ACC_W-1:0] BIAS_SHORT =
        (ACC_W'(1) <<< GAIN_FRAC) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] BIAS_LONG =
        (ACC_W'(1) <<< (GAIN_FRAC + ANGLE_FRAC)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ACC_DRIVE_MAX =
        $signed({{(ACC_W - DRIVE_W + 1){1'b0}}, {(DRIVE_W - 1){1'b1}}});
    localparam logic signed [ACC_W-1:0] ACC_DRIVE_MIN =
        $signed({{(ACC_W - DRIVE_W + 1){1'b1}}, {(DRIVE_W - 1){1'b0}}});

    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [ACC_W-1:0] x
    );
        logic signed [DRIVE_W-1:0] y;
        if (x > ACC_DRIVE_MAX) begin
            y = ACC_DRIVE_MAX[DRIVE_W-1:0];
        end else if (x < ACC_DRIVE_MIN) begin
            y = ACC_DRIVE_MIN[DRIVE_W-1:0];
        end else begin
            y = x[DRIVE_W-1:0];
        end
        return y;
    endfunction

    t_op op;
    assign op = i_cmd.op;

    // latched item
    logic signed [COUNT_W-1:0] r_left_count, r_right_count;
    logic signed [ANGLE_W-1:0] r_pitch_angle;
    logic signed [RATE_W-1:0]  r_pitch_rate, r_yaw_rate;
    logic [ECHO_W-1:0]         r_echo_time;
    logic                      r_go, r_back, r_lb, r_rb;

    // loop state
    logic signed [TGT_W-1:0]  r_target, n_target;
    logic signed [TURN_W-1:0] r_turn, n_turn;
    logic [DAMP_W-1:0]        r_damp, n_damp;
    logic signed [FE_W-1:0]   r_fe, n_fe;
    logic signed [SUM_W-1:0]  r_sum, n_sum;

    // working registers
    logic                       r_neg;
    logic [MAG_W-1:0]           r_mag;
    logic signed [PROD_W-1:0]   r_prod, r_kv;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [DRIVE_W-1:0]  r_v, r_a, r_pwm, r_t;
    logic signed [DRIVE_W-1:0]  r_motor_one, r_motor_two, r_speed_term;

    logic signed [TGT_W+1:0]    tgt_step;
    logic signed [TURN_W:0]     turn_step;
    logic signed [ERR_W-1:0]    err;
    logic signed [NUM_W-1:0]    num, num_abs;
    logic [FE_W-2:0]            fe_quo;
    logic signed [FE_W-1:0]     fe_abs;
    logic signed [FE_W:0]       sum_raw;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic                       sh_long;
    logic signed [ACC_W-1:0]    bias, biased, quo;
    logic signed [DRIVE_W-1:0]  quo_sat;

    // target, turn and damping update by mode
    always_comb begin
        n_target  = r_target;
        n_turn    = r_turn;
        n_damp    = r_damp;
        tgt_step  = (TGT_W + 2)'(r_target);
        turn_step = (TURN_W + 1)'(r_turn);
        unique case (i_cfg.mode)
            MODE_OBSTACLE: begin
                n_target = (r_echo_time <= OBSTACLE_ECHO) ? OBSTACLE_SPEED : '0;
            end
            MODE_REMOTE: begin
                if (!r_go && !r_back) begin
                    if (tgt_step > 0) begin
                        tgt_step = tgt_step - (TGT_W + 2)'(1);
                    end else if (tgt_step < 0) begin
                        tgt_step = tgt_step + (TGT_W + 2)'(1);
                    end
                end
                if (r_go) begin
                    tgt_step = tgt_step + (TGT_W + 2)'(1);
                end
                if (r_back) begin
                    tgt_step = (TGT_W + 2)'(BACK_SPEED);
                end
                if (tgt_step > SPEED_LIMIT) begin
                    n_target = SPEED_LIMIT;
                end else if (tgt_step < -SPEED_LIMIT) begin
                    n_target = -SPEED_LIMIT;
                end else begin
                    n_target = tgt_step[TGT_W-1:0];
                end
                if (!r_lb && !r_rb) begin
                    turn_step = '0;
                end
                if (r_lb) begin
                    turn_step = turn_step - (TURN_W + 1)'(1);
                end
                if (r_rb) begin
                    turn_step = turn_step + (TURN_W + 1)'(1);
                end
                if (turn_step > MAX_TURN) begin
                    n_turn = MAX_TURN;
                end else if (turn_step < -MAX_TURN) begin
                    n_turn = -MAX_TURN;
                end else begin
                    n_turn = turn_step[TURN_W-1:0];
                end
                n_damp = (!r_lb && !r_rb) ? DAMP_IDLE : '0;
            end
            default: ;
        endcase
    end

    // speed error and low-pass numerator
    assign err = ERR_W'(r_right_count) - ERR_W'(r_left_count) - ERR_W'(r_target);
    assign num = NUM_W'(FILT_NEW * NUM_W'(err) + FILT_OLD * NUM_W'(r_fe));
    assign num_abs = num[NUM_W-1] ? -num : num;

    // quotient by ten from the reciprocal product, sign restored
    assign fe_quo  = r_prod[RECIP_SHIFT +: FE_W-1];
    assign fe_abs  = $signed({1'b0, fe_quo});
    assign n_fe    = r_neg ? -fe_abs : fe_abs;
    assign sum_raw = (FE_W + 1)'(r_sum) + (FE_W + 1)'(n_fe);

    always_comb begin
        if (sum_raw > SUM_LIMIT) begin
            n_sum = SUM_LIMIT;
        end else if (sum_raw < -SUM_LIMIT) begin
            n_sum = -SUM_LIMIT;
        end else begin
            n_sum = sum_raw[SUM_W-1:0];
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            OP_DIV: begin
                mul_a = $signed(MUL_W'(r_mag));
                mul_b = RECIP_TEN;
            end
            OP_V_MUL_P: begin
                mul_a = $signed(i_cfg.speed_kp);
                mul_b = MUL_W'(r_fe);
            end
            OP_V_MUL_I: begin
                mul_a = $signed(i_cfg.speed_ki);
                mul_b = MUL_W'(r_sum);
            end
            OP_A_MUL_P: begin
                mul_a = $signed(i_cfg.angle_kp);
                mul_b = MUL_W'(r_pitch_angle) - MUL_W'($signed(i_cfg.balance_angle));
            end
            OP_A_MUL_D: begin
                mul_a = $signed(i_cfg.angle_kd);
                mul_b = MUL_W'(r_pitch_rate);
            end
            OP_A_MUL_V: begin
                mul_a = $signed(i_cfg.angle_kp);
                mul_b = r_v;
            end
            OP_T_MUL_D: begin
                mul_a = $signed(MUL_W'(r_damp));
                mul_b = MUL_W'(r_yaw_rate);
            end
            OP_T_MUL_P: begin
                mul_a = $signed(i_cfg.yaw_kp);
                mul_b = MUL_W'(r_turn);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // truncate toward zero after the binary point, then saturate
    assign sh_long = (op == OP_A_DONE);
    assign bias    = !r_acc[ACC_W-1] ? '0 : (sh_long ? BIAS_LONG : BIAS_SHORT);
    assign biased  = r_acc + bias;
    assign quo     = sh_long ? (biased >>> (GAIN_FRAC + ANGLE_FRAC))
                             : (biased >>> GAIN_FRAC);
    assign quo_sat = sat_drive(quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_turn   <= TURN_RESET;
            r_damp   <= DAMP_RESET;
            r_fe     <= '0;
            r_sum    <= '0;
        end else begin
            if (op == OP_TARGET) begin
                r_target <= n_target;
                r_turn   <= n_turn;
                r_damp   <= n_damp;
            end
            if (op == OP_FILT) begin
                r_fe  <= n_fe;
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (op)
            OP_LOAD: begin
                r_left_count  <= i_left_count;
                r_right_count <= i_right_count;
                r_pitch_angle <= i_pitch_angle;
                r_pitch_rate  <= i_pitch_rate;
                r_yaw_rate    <= i_yaw_rate;
                r_echo_time   <= i_echo_time;
                r_go          <= i_go_button;
                r_back        <= i_back_button;
                r_lb          <= i_left_button;
                r_rb          <= i_right_button;
            end
            OP_FILT_NUM: begin
                r_neg <= num[NUM_W-1];
                r_mag <= num_abs[MAG_W-1:0];
            end
            OP_V_MUL_I, OP_A_MUL_D, OP_T_MUL_P: r_acc <= ACC_W'(r_prod);
            OP_V_ADD, OP_T_ADD:                 r_acc <= r_acc + ACC_W'(r_prod);
            OP_A_MUL_V: r_acc <= r_acc + (ACC_W'(r_prod) <<< ANGLE_FRAC);
            OP_A_SUB: begin
                r_acc <= r_acc - (ACC_W'(r_prod) <<< ANGLE_FRAC);
                r_kv  <= r_prod;
            end
            OP_P_DIFF: r_acc <= (ACC_W'(r_a) <<< GAIN_FRAC) - ACC_W'(r_kv);
            OP_V_DONE: r_v   <= quo_sat;
            OP_A_DONE: r_a   <= quo_sat;
            OP_P_DONE: r_pwm <= quo_sat;
            OP_T_DONE: r_t   <= quo_sat;
            OP_OUT: begin
                r_motor_one  <= sat_drive(ACC_W'(r_pwm) - ACC_W'(r_t));
                r_motor_two  <= sat_drive(ACC_W'(r_pwm) + ACC_W'(r_t));
                r_speed_term <= r_v;
            end
            default: ;
        endcase
    end

    assign o_motor_one  = r_motor_one;
    assign o_motor_two  = r_motor_two;
    assign o_speed_term = r_speed_term;

endmodule

>>> src/balance_cascade_controller_unit.sv
// balance cascade controller: one item per control tick in, one pair of motor
// drives and the speed loop term out; an item runs from acceptance to the
// result register one sequencer step a cycle, held only while a full result
// register is not taken; the speed, angle and yaw loops use the single shared
// 32x32 multiplier in turn; the input opens again with the result, so an item
// is taken only once the last one is finished; the result register holds a
// finished item while the next one is taken; configuration writes are taken
// every cycle; depends on bcc_pkg, bcc_cfg, bcc_ctrl and bcc_dp
module balance_cascade_controller_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [bcc_pkg::COUNT_W-1:0]  i_left_count,
    input  logic signed [bcc_pkg::COUNT_W-1:0]  i_right_count,
    input  logic signed [bcc_pkg::ANGLE_W-1:0]  i_pitch_angle,
    input  logic signed [bcc_pkg::RATE_W-1:0]   i_pitch_rate,
    input  logic signed [bcc_pkg::RATE_W-1:0]   i_yaw_rate,
    input  logic [bcc_pkg::ECHO_W-1:0]          i_echo_time,
    input  logic                                i_go_button,
    input  logic                                i_back_button,
    input  logic                                i_left_button,
    input  logic                                i_right_button,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bcc_pkg::DRIVE_W-1:0]  o_motor_one,
    output logic signed [bcc_pkg::DRIVE_W-1:0]  o_motor_two,
    output logic signed [bcc_pkg::DRIVE_W-1:0]  o_speed_term,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bcc_pkg::*;

    t_cfg cfg;
    t_cmd cmd;

    bcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    bcc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_left_count   (i_left_count),
        .i_right_count  (i_right_count),
        .i_pitch_angle  (i_pitch_angle),
        .i_pitch_rate   (i_pitch_rate),
        .i_yaw_rate     (i_yaw_rate),
        .i_echo_time    (i_echo_time),
        .i_go_button    (i_go_button),
        .i_back_button  (i_back_button),
        .i_left_button  (i_left_button),
        .i_right_button (i_right_button),
        .o_motor_one    (o_motor_one),
        .o_motor_two    (o_motor_two),
        .o_speed_term   (o_speed_term)
    );

endmodule

>>> src/bcc_checker.sv
// bcc_checker: port-level checks of the balance cascade controller and the
// bind that attaches them; depends on bcc_pkg and the top level
module bcc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic signed [bcc_pkg::COUNT_W-1:0]  i_left_count,
    input logic signed [bcc_pkg::COUNT_W-1:0]  i_right_count,
    input logic signed [bcc_pkg::ANGLE_W-1:0]  i_pitch_angle,
    input logic signed [bcc_pkg::RATE_W-1:0]   i_pitch_rate,
    input logic signed [bcc_pkg::RATE_W-1:0]   i_yaw_rate,
    input logic [bcc_pkg::ECHO_W-1:0]          i_echo_time,
    input logic                                i_go_button,
    input logic                                i_back_button,
    input logic                                i_left_button,
    input logic                                i_right_button,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [bcc_pkg::DRIVE_W-1:0]  o_motor_one,
    input logic signed [bcc_pkg::DRIVE_W-1:0]  o_motor_two,
    input logic signed [bcc_pkg::DRIVE_W-1:0]  o_speed_term,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [bcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input logic [bcc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bcc_pkg::*;

    // reset leaves no result and an open input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result or busy after reset");

    // an accepted item closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input open right after an item was taken");

    // a new result comes together with the input opening again
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while still busy");

    // a stalled result holds
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_motor_one)
            && $stable(o_motor_two) && $stable(o_speed_term))
        else $error("stalled result changed");

endmodule

bind balance_cascade_controller_unit bcc_checker u_bcc_checker (.*);
